### sv/ccce_pkg.sv
`default_nettype none
package ccce_pkg;
    typedef enum logic [2:0] {
        CMD_WR_MATRIX = 3'd0,
        CMD_WR_BOUND  = 3'd1,
        CMD_CLEAR     = 3'd2,
        CMD_STEP      = 3'd3,
        CMD_QUERY     = 3'd4
    } cmd_t;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_DIMS = 2'd1;
    localparam logic [1:0] REG_EPS  = 2'd2;

    localparam logic signed [31:0] T_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_NEG = -32'sh7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         row;
        logic [3:0]         coord;
        logic signed [31:0] value;
    } item_t;
endpackage
`default_nettype wire

### sv/ccce_ram.sv
`default_nettype none
module ccce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/ccce_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; signed, truncating toward zero,
// quotient saturated to +-(2^31-1).
module ccce_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quo
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_next;
    logic [64:0] trial;
    logic [63:0] shifted;
    logic [63:0] q_mag;
    logic signed [63:0] q_signed;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[62:0], q_reg[63]};
        trial     = {1'b0, shifted} - {33'd0, d_reg};
        if (start)
        begin
            rem_next  = '0;
            q_next    = num[63] ? 64'(-num) : 64'(num);
            d_next    = den[31] ? 32'(-den) : 32'(den);
            neg_next  = num[63] ^ den[31];
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[62:0], ~trial[64]};
            rem_next = trial[64] ? shifted : trial[63:0];
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done     <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign q_mag    = q_reg;
    assign q_signed = neg_reg ? -$signed(q_mag) : $signed(q_mag);
    assign quo = (q_signed > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (q_signed < -64'sh7FFF_FFFF) ? -32'sh7FFF_FFFF : q_signed[31:0];
endmodule
`default_nettype wire

### sv/ccce_front.sv
`default_nettype none
// Front end: takes input transfers, drops unknown commands, queues the rest.
module ccce_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [2:0]     command,
    input  wire logic [5:0]     row,
    input  wire logic [3:0]     coord,
    input  wire logic [31:0]    matrix_value,
    input  wire logic [31:0]    bound_value,
    input  wire logic [31:0]    step,
    output logic                q_valid,
    output ccce_pkg::item_t     q_item,
    input  wire logic           q_take
);
    import ccce_pkg::*;
    item_t      slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    item_t      in_item;
    logic       acc, keep;

    always_comb
    begin
        in_item.cmd   = command;
        in_item.row   = row;
        in_item.coord = coord;
        case (command)
            CMD_WR_MATRIX: in_item.value = matrix_value;
            CMD_WR_BOUND:  in_item.value = bound_value;
            default:       in_item.value = step;
        endcase
    end

    assign full    = (cnt_reg == 2'd2);
    assign acc     = push && !full;
    assign keep    = acc && (command <= CMD_QUERY);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_reg];
    assign cnt_next = cnt_reg + {1'b0, keep} - {1'b0, q_take && q_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (keep) wr_reg <= ~wr_reg;
            if (q_take && q_valid) rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep) slot_reg[wr_reg] <= in_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !keep)
        else $error("write into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (rd_reg == wr_reg))
        else $error("pointers disagree on empty queue");
endmodule
`default_nettype wire

### sv/ccce_back.sv
`default_nettype none
// Back end: row walker for steps and queries, with the three stores.
module ccce_back #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_DIMS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  ccce_pkg::item_t      q_item,
    output logic                 q_take,
    input  wire logic [6:0]      rows_used,
    input  wire logic [4:0]      dims_used,
    input  wire logic [15:0]     orth_eps,
    output logic                 res_valid,
    output logic signed [31:0]   res_low,
    output logic signed [31:0]   res_high,
    input  wire logic            res_take
);
    import ccce_pkg::*;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int MD  = MAX_ROWS * MAX_DIMS;
    localparam int MW  = (MD > 1) ? $clog2(MD) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_MUL = 7'b0000100,
        S_ADD  = 7'b0001000, S_DIV = 7'b0010000, S_WAIT = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t              st_reg, st_next;
    item_t               it_reg;
    logic [RW:0]         idx_reg;
    logic [RW:0]         nrows;
    logic [DW:0]         ndims;
    logic signed [31:0]  lo_reg, hi_reg;
    logic signed [63:0]  prod_reg;
    logic                clr_reg;
    logic [MAX_ROWS-1:0] cvalid_reg;
    logic                div_start;
    logic                div_done;
    logic signed [31:0]  div_q;
    logic signed [31:0]  a_rd, b_rd, c_rd_raw, c_rd;
    logic                a_neg_reg;
    logic                m_we, b_we, c_we;
    logic [MW-1:0]       m_waddr, m_raddr;
    logic [RW-1:0]       row_idx;
    logic signed [31:0]  c_wdata;
    logic signed [63:0]  inc64, sum64;
    logic signed [32:0]  a_abs;
    logic                addr_ok;

    assign nrows   = (32'(rows_used) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(rows_used);
    assign ndims   = (32'(dims_used) > MAX_DIMS) ? (DW+1)'(MAX_DIMS) : (DW+1)'(dims_used);
    assign row_idx = idx_reg[RW-1:0];
    assign addr_ok = (32'(q_item.row) < MAX_ROWS) && (32'(q_item.coord) < MAX_DIMS);

    assign m_we    = (st_reg == S_IDLE) && q_valid && q_item.cmd == CMD_WR_MATRIX && addr_ok;
    assign b_we    = (st_reg == S_IDLE) && q_valid && q_item.cmd == CMD_WR_BOUND
                     && (32'(q_item.row) < MAX_ROWS);
    assign m_waddr = MW'(32'(q_item.row) * MAX_DIMS + 32'(q_item.coord));
    assign m_raddr = MW'(32'(row_idx) * MAX_DIMS + 32'(it_reg.coord));

    ccce_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(q_item.value),
        .raddr(m_raddr), .rdata(a_rd));
    ccce_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_bnd (
        .clk(clk), .we(b_we), .waddr(RW'(q_item.row)), .wdata(q_item.value),
        .raddr(row_idx), .rdata(b_rd));
    ccce_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_cache (
        .clk(clk), .we(c_we), .waddr(row_idx), .wdata(c_wdata),
        .raddr(row_idx), .rdata(c_rd_raw));

    // The cache read is qualified by a valid bit per row; clear drops them all.
    always_ff @(posedge clk)
    begin
        clr_reg <= cvalid_reg[row_idx];
    end
    assign c_rd = clr_reg ? c_rd_raw : 32'sd0;

    assign inc64 = (prod_reg >>> 16) > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF :
                   (prod_reg >>> 16) < -64'sh8000_0000 ? -64'sh8000_0000 :
                   (prod_reg >>> 16);
    assign sum64 = 64'(c_rd) + inc64;
    assign c_wdata = sum64 > 64'sh7FFF_FFFF ? 32'sh7FFF_FFFF :
                     sum64 < -64'sh8000_0000 ? 32'sh8000_0000 : sum64[31:0];
    assign c_we = (st_reg == S_ADD);
    assign a_abs = a_rd[31] ? -33'(a_rd) : 33'(a_rd);
    assign div_start = (st_reg == S_MUL) && (it_reg.cmd == CMD_QUERY)
                       && (a_abs > 33'(orth_eps));

    ccce_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num((64'(b_rd) - 64'(c_rd)) <<< 16), .den(a_rd),
        .done(div_done), .quo(div_q));

    assign q_take    = (st_reg == S_IDLE) && q_valid;
    assign res_valid = (st_reg == S_OUT);
    assign res_low   = lo_reg;
    assign res_high  = hi_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (q_valid && (q_item.cmd == CMD_STEP || q_item.cmd == CMD_QUERY))
                begin
                    if ((nrows == '0) || (32'(q_item.coord) >= 32'(ndims)))
                        st_next = (q_item.cmd == CMD_QUERY) ? S_OUT : S_IDLE;
                    else
                        st_next = S_RD;
                end
            end
            S_RD:  st_next = S_MUL;
            S_MUL:
            begin
                if (it_reg.cmd == CMD_STEP) st_next = S_ADD;
                else if (div_start) st_next = S_DIV;
                else st_next = (idx_reg + 1'b1 >= nrows) ? S_OUT : S_RD;
            end
            S_ADD: st_next = (idx_reg + 1'b1 >= nrows) ? S_IDLE : S_RD;
            S_DIV: st_next = S_WAIT;
            S_WAIT:
            begin
                if (div_done) st_next = (idx_reg + 1'b1 >= nrows) ? S_OUT : S_RD;
            end
            S_OUT: if (res_take) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            cvalid_reg <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (q_take && q_item.cmd == CMD_CLEAR) cvalid_reg <= '0;
            if (c_we) cvalid_reg[row_idx] <= 1'b1;
            if (q_take) idx_reg <= '0;
            else if ((st_reg == S_ADD) || (st_reg == S_WAIT && div_done)
                     || (st_reg == S_MUL && it_reg.cmd == CMD_QUERY && !div_start))
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            it_reg <= q_item;
            lo_reg <= T_NEG;
            hi_reg <= T_POS;
        end
        if (st_reg == S_MUL)
        begin
            prod_reg  <= 64'(it_reg.value) * 64'(a_rd);
            a_neg_reg <= a_rd[31];
        end
        if (st_reg == S_WAIT && div_done)
        begin
            if (a_neg_reg) begin if (div_q > lo_reg) lo_reg <= div_q; end
            else begin if (div_q < hi_reg) hi_reg <= div_q; end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (st_reg == S_WAIT))
        else $error("divider finished outside wait");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_OUT) && !res_take |=> (st_reg == S_OUT) && $stable(lo_reg))
        else $error("result dropped");
endmodule
`default_nettype wire

### sv/cached_coordinate_chord_engine.sv
`default_nettype none
// Channel   Handshake      Payload
// input     push / full    command, row, coord, matrix_value, bound_value, step
// result    empty / pop    t_low, t_high
// config    cfg_we         cfg_index, cfg_data (rows_used, dims_used, orth_eps)
//
// Writes and clears are taken by the back end while it is idle. A step walks each
// used row through the read, multiply and add states; a query walks each row through
// read and multiply, and a non-orthogonal row also waits on the bit-serial divider.
// Reset clears the queues, the state machine and the per-row cache valid bits.
// A two-entry queue between front and back lets input transfers continue while
// a row walk runs; a one-entry result buffer holds the chord until popped.
module cached_coordinate_chord_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_DIMS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  command,
    input  wire logic [5:0]  row,
    input  wire logic [3:0]  coord,
    input  wire logic [31:0] matrix_value,
    input  wire logic [31:0] bound_value,
    input  wire logic [31:0] step,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      t_low,
    output logic [31:0]      t_high,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import ccce_pkg::*;
    logic        q_valid, q_take;
    item_t       q_item;
    logic [6:0]  rows_reg;
    logic [4:0]  dims_reg;
    logic [15:0] eps_reg;
    logic        res_valid;
    logic signed [31:0] res_low, res_high;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 7'd64;
            dims_reg <= 5'd16;
            eps_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS: rows_reg <= cfg_data[6:0];
                REG_DIMS: dims_reg <= cfg_data[4:0];
                REG_EPS:  eps_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    ccce_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .row(row), .coord(coord), .matrix_value(matrix_value),
        .bound_value(bound_value), .step(step),
        .q_valid(q_valid), .q_item(q_item), .q_take(q_take));

    ccce_back #(.MAX_ROWS(MAX_ROWS), .MAX_DIMS(MAX_DIMS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .rows_used(rows_reg), .dims_used(dims_reg),
        .orth_eps(eps_reg), .res_valid(res_valid), .res_low(res_low),
        .res_high(res_high), .res_take(pop));

    // The back end holds its result until the pop transfer.
    assign empty  = !res_valid;
    assign t_low  = res_low;
    assign t_high = res_high;
endmodule
`default_nettype wire
